### src/pvem_pkg.sv
// ----------------------------------------------------------------------------
// Voice envelope manager package
// Shared widths, codes and transaction types for the voice envelope manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pvem_pkg;

   // Voice bank size and derived index width
   localparam int VOICES     = 8;
   localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;

   // Field widths
   localparam int OP_W       = 2;
   localparam int KEY_W      = 7;
   localparam int LEVEL_W    = 17;
   localparam int STAGE_W    = 3;
   localparam int OUT_IDX_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(65536);

   // Opcodes
   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_KEY_ON  = 2'd1;
   localparam logic [OP_W-1:0] OP_KEY_OFF = 2'd2;

   // Envelope stages
   localparam logic [STAGE_W-1:0] STAGE_OFF     = 3'd0;
   localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 3'd1;
   localparam logic [STAGE_W-1:0] STAGE_DECAY   = 3'd2;
   localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 3'd3;
   localparam logic [STAGE_W-1:0] STAGE_RELEASE = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENV_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN_LEVEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_STEP  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [KEY_W-1:0] note_key;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] voice_index;
      logic [LEVEL_W-1:0]   level;
      logic [STAGE_W-1:0]   stage;
      logic [KEY_W-1:0]     voice_key;
      logic                 held;
      logic                 granted;
      logic                 last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_KEY_ON,
      CMD_KEY_OFF
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [KEY_W-1:0] key;
   } cmd_type;

   typedef struct packed {
      logic               env_mode;
      logic [LEVEL_W-1:0] attack_step;
      logic [LEVEL_W-1:0] decay_step;
      logic [LEVEL_W-1:0] sustain_level;
      logic [LEVEL_W-1:0] release_step;
   } cfg_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic pop;
      logic ticking;
   } back_status_type;

endpackage

`default_nettype wire

### src/pvem_front.sv
// ----------------------------------------------------------------------------
// Voice envelope manager front end
// Takes commands, drops the unused opcode and hands them to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvem_front import pvem_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire req_type  req_item,
   input  wire logic     q_full,
   output logic          busy,
   output logic          push,
   output cmd_type       push_cmd
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    accept;
   logic    op_known;
   cmd_type decoded;

   assign busy     = hold_valid_ff & q_full;
   assign push     = hold_valid_ff & ~q_full;
   assign push_cmd = hold_cmd_ff;
   assign accept   = start & ~busy;

   always_comb begin
      decoded.key = req_item.note_key;
      op_known    = 1'b1;
      unique case (req_item.opcode)
         OP_TICK:    decoded.kind = CMD_TICK;
         OP_KEY_ON:  decoded.kind = CMD_KEY_ON;
         OP_KEY_OFF: decoded.kind = CMD_KEY_OFF;
         default: begin
            decoded.kind = CMD_TICK;
            op_known     = 1'b0;
         end
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (accept && op_known) begin
         hold_valid_in = 1'b1;
         hold_cmd_in   = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

`default_nettype wire

### src/pvem_queue.sv
// ----------------------------------------------------------------------------
// Voice envelope manager command queue
// Short FIFO decoupling the front end from the voice engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvem_queue import pvem_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire cmd_type    push_cmd,
   input  wire logic       pop,
   output cmd_type         head_cmd,
   output queue_status_type status
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### src/pvem_back.sv
// ----------------------------------------------------------------------------
// Voice envelope manager voice engine
// Holds the voice bank, runs key on / key off and walks voices on a tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvem_back import pvem_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire queue_status_type q_status,
   input  wire cmd_type          head_cmd,
   output back_status_type       status,
   output logic                  rsp_valid,
   output rsp_type               rsp_item
);

   typedef enum logic {
      BK_IDLE,
      BK_TICK
   } back_state_type;

   typedef struct packed {
      logic [STAGE_W-1:0] stage;
      logic [LEVEL_W-1:0] level;
   } voice_env_type;

   back_state_type     state_ff, state_in;
   logic [VIDX_W-1:0]  cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [STAGE_W-1:0] stage_ff [VOICES];
   logic [STAGE_W-1:0] stage_in [VOICES];
   logic [LEVEL_W-1:0] level_ff [VOICES];
   logic [LEVEL_W-1:0] level_in [VOICES];
   logic [KEY_W-1:0]   key_ff   [VOICES];
   logic [KEY_W-1:0]   key_in   [VOICES];
   logic               held_ff  [VOICES];
   logic               held_in  [VOICES];

   logic               free_found, off_found;
   logic [VIDX_W-1:0]  free_idx, off_idx;
   logic [VOICES-1:0]  off_match;
   voice_env_type      tick_next;
   logic               pop;

   // One envelope step for one voice
   function automatic voice_env_type env_advance(
      input logic [STAGE_W-1:0] stage,
      input logic [LEVEL_W-1:0] level,
      input cfg_type            c
   );
      voice_env_type      r;
      logic [LEVEL_W-1:0] sus;
      logic [LEVEL_W:0]   sum;
      r.stage = stage;
      r.level = level;
      sus = (c.sustain_level > FULL_SCALE) ? FULL_SCALE : c.sustain_level;
      sum = {1'b0, level} + {1'b0, c.attack_step};
      case (stage)
         STAGE_ATTACK: begin
            if (sum >= {1'b0, FULL_SCALE}) begin
               r.level = FULL_SCALE;
               r.stage = c.env_mode ? STAGE_RELEASE : STAGE_DECAY;
            end else begin
               r.level = sum[LEVEL_W-1:0];
            end
         end
         STAGE_DECAY: begin
            if (!c.env_mode) begin
               // level - step <= sus, rearranged to stay unsigned
               if ({1'b0, level} <= ({1'b0, sus} + {1'b0, c.decay_step})) begin
                  r.level = sus;
                  r.stage = STAGE_SUSTAIN;
               end else begin
                  r.level = level - c.decay_step;
               end
            end
         end
         STAGE_RELEASE: begin
            if (level <= c.release_step) begin
               r.level = '0;
               r.stage = STAGE_OFF;
            end else begin
               r.level = level - c.release_step;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item       = rsp_ff;
   assign status.pop     = pop;
   assign status.ticking = (state_ff == BK_TICK);

   // Lowest free voice and lowest sounding voice with the key
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      off_found  = 1'b0;
      off_idx    = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         off_match[i] = (key_ff[i] == head_cmd.key) && (stage_ff[i] != STAGE_OFF);
         if (!held_ff[i] && stage_ff[i] == STAGE_OFF) begin
            free_found = 1'b1;
            free_idx   = VIDX_W'(i);
         end
         if (off_match[i]) begin
            off_found = 1'b1;
            off_idx   = VIDX_W'(i);
         end
      end
   end

   assign tick_next = env_advance(stage_ff[cnt_ff], level_ff[cnt_ff], cfg);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      stage_in     = stage_ff;
      level_in     = level_ff;
      key_in       = key_ff;
      held_in      = held_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               unique case (head_cmd.kind)
                  CMD_TICK: begin
                     state_in = BK_TICK;
                     cnt_in   = '0;
                  end
                  CMD_KEY_ON: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     rsp_in.last  = 1'b1;
                     if (free_found) begin
                        stage_in[free_idx]  = STAGE_ATTACK;
                        level_in[free_idx]  = '0;
                        key_in[free_idx]    = head_cmd.key;
                        held_in[free_idx]   = 1'b1;
                        rsp_in.voice_index  = OUT_IDX_W'(free_idx);
                        rsp_in.stage        = STAGE_ATTACK;
                        rsp_in.voice_key    = head_cmd.key;
                        rsp_in.held         = 1'b1;
                        rsp_in.granted      = 1'b1;
                     end
                  end
                  CMD_KEY_OFF: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     rsp_in.last  = 1'b1;
                     for (int i = 0; i < VOICES; i++) begin
                        if (off_match[i]) begin
                           held_in[i]  = 1'b0;
                           stage_in[i] = STAGE_RELEASE;
                        end
                     end
                     if (off_found) begin
                        rsp_in.voice_index = OUT_IDX_W'(off_idx);
                        rsp_in.level       = level_ff[off_idx];
                        rsp_in.stage       = STAGE_RELEASE;
                        rsp_in.voice_key   = head_cmd.key;
                        rsp_in.granted     = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_TICK: begin
            stage_in[cnt_ff]   = tick_next.stage;
            level_in[cnt_ff]   = tick_next.level;
            rsp_valid_in       = 1'b1;
            rsp_in.voice_index = OUT_IDX_W'(cnt_ff);
            rsp_in.level       = tick_next.level;
            rsp_in.stage       = tick_next.stage;
            rsp_in.voice_key   = key_ff[cnt_ff];
            rsp_in.held        = held_ff[cnt_ff];
            rsp_in.granted     = 1'b0;
            rsp_in.last        = (cnt_ff == VIDX_W'(VOICES - 1));
            if (cnt_ff == VIDX_W'(VOICES - 1)) begin
               state_in = BK_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            stage_ff[i] <= STAGE_OFF;
            level_ff[i] <= '0;
            key_ff[i]   <= '0;
            held_ff[i]  <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         stage_ff     <= stage_in;
         level_ff     <= level_in;
         key_ff       <= key_in;
         held_ff      <= held_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

### src/polyphonic_voice_envelope_manager.sv
// ----------------------------------------------------------------------------
// Polyphonic voice envelope manager
// Voice allocator with a per-voice attack/decay/sustain/release envelope.
// ----------------------------------------------------------------------------
// Usage:
//  - Commands: drive req_item and raise start; the transaction is taken on
//    the rising edge where start is high and busy is low. Opcodes: tick,
//    key on, key off. The unused opcode is taken and dropped, no result.
//  - Results: rsp_valid strobes for one cycle per result transaction; the
//    receiver must take it then, there is no back-pressure. last marks the
//    final result of a command.
//  - Key on / key off give one result each; a command passes the front
//    register and the queue before the engine takes it and registers its
//    result. A tick gives one result per voice, in voice order, back to back.
//  - Throughput: the voice engine walks one voice per cycle through a single
//    envelope step unit and pops no command until a tick's walk is done; key
//    on and key off are done in the cycle they are popped. A two-entry queue
//    plus the front register buffer commands; busy rises when both are full.
//  - Registers: csr_we / csr_index / csr_wdata write one register per cycle;
//    write them only while no command is in flight.
//  - Reset (synchronous): all voices off with level, key and held cleared,
//    registers to their defaults, queue empty, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_voice_envelope_manager import pvem_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_item,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   output rsp_type                    rsp_item
);

   cfg_type          cfg_ff, cfg_in;
   logic             push;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type q_status;
   back_status_type  back_status;

   // Register file: plain write port, no read-back
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENV_MODE:      cfg_in.env_mode      = csr_wdata[0];
            CSR_ATTACK_STEP:   cfg_in.attack_step   = LEVEL_W'(csr_wdata);
            CSR_DECAY_STEP:    cfg_in.decay_step    = LEVEL_W'(csr_wdata);
            CSR_SUSTAIN_LEVEL: cfg_in.sustain_level = LEVEL_W'(csr_wdata);
            CSR_RELEASE_STEP:  cfg_in.release_step  = LEVEL_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.env_mode      <= 1'b0;
         cfg_ff.attack_step   <= LEVEL_W'(66);
         cfg_ff.decay_step    <= LEVEL_W'(66);
         cfg_ff.sustain_level <= LEVEL_W'(45875);
         cfg_ff.release_step  <= LEVEL_W'(66);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: takes and classifies command transactions
   pvem_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .q_full   (q_status.full),
      .busy     (busy),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // Decoupling queue
   pvem_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (back_status.pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // Voice engine
   pvem_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .head_cmd  (head_cmd),
      .status    (back_status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Envelope level never exceeds full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.level <= FULL_SCALE))
      else $error("level above full scale");

   // A granted voice in attack was just taken: held, level zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.granted && rsp_item.stage == STAGE_ATTACK)
         |-> (rsp_item.held && rsp_item.level == '0))
      else $error("key on result not a fresh voice");

   // Every walk cycle of a tick produces a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      back_status.ticking |=> rsp_valid)
      else $error("tick walk missed a result");

   // The front end never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Voice envelope manager testbench
// Drives key on, key off and tick commands into the voice bank and checks
// every result transaction against a cycle-free envelope predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import pvem_pkg::*;

   // The fourth opcode has no meaning; the block takes it and drops it
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int RESET_CYCLES   = 9;
   // Quiet cycles after the last expected result before registers change
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS    = 10;

   // -------------------------------------------------------------------------
   // DUT connections, all inputs known from time zero
   // -------------------------------------------------------------------------
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_item  = '0;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  rsp_valid;
   rsp_type               rsp_item;

   polyphonic_voice_envelope_manager i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   // -------------------------------------------------------------------------
   // Predictor state: a shadow of the voice bank and of the registers
   // -------------------------------------------------------------------------
   logic [STAGE_W-1:0] env_stage [VOICES];
   logic [LEVEL_W-1:0] env_level [VOICES];
   logic [KEY_W-1:0]   held_key  [VOICES];
   logic               key_down  [VOICES];
   cfg_type            settings;

   rsp_type expected_reports [$];
   int      error_count  = 0;
   int      quiet_cycles = 0;
   bit      idle_enabled = 1'b1;

   // -------------------------------------------------------------------------
   // Envelope predictor
   // -------------------------------------------------------------------------

   // One envelope step for one voice. Arithmetic runs in int so that the
   // overshoot past full scale or below zero is seen before the clamp.
   function automatic void advance_voice(int v);
      int lvl;
      int target;
      lvl    = int'(env_level[v]);
      // sustain register above full scale saturates the decay target
      target = (settings.sustain_level > FULL_SCALE) ? int'(FULL_SCALE)
                                                     : int'(settings.sustain_level);
      case (env_stage[v])
         STAGE_ATTACK: begin
            lvl += int'(settings.attack_step);
            if (lvl >= int'(FULL_SCALE)) begin
               lvl          = int'(FULL_SCALE);
               // AR mode skips decay and sustain entirely
               env_stage[v] = settings.env_mode ? STAGE_RELEASE : STAGE_DECAY;
            end
         end
         STAGE_DECAY: begin
            // a voice caught in decay by a switch to AR mode just holds
            if (!settings.env_mode) begin
               lvl -= int'(settings.decay_step);
               if (lvl <= target) begin
                  lvl          = target;
                  env_stage[v] = STAGE_SUSTAIN;
               end
            end
         end
         STAGE_RELEASE: begin
            lvl -= int'(settings.release_step);
            if (lvl <= 0) begin
               lvl          = 0;
               env_stage[v] = STAGE_OFF;
            end
         end
         default: ;  // sustain and off hold
      endcase
      env_level[v] = lvl[LEVEL_W-1:0];
   endfunction

   function automatic rsp_type voice_report(int v, logic granted, logic last);
      rsp_type r;
      r.voice_index = OUT_IDX_W'(v);
      r.level       = env_level[v];
      r.stage       = env_stage[v];
      r.voice_key   = held_key[v];
      r.held        = key_down[v];
      r.granted     = granted;
      r.last        = last;
      return r;
   endfunction

   // Key on with a full bank, or key off with nothing to release
   function automatic rsp_type no_voice_report();
      rsp_type r;
      r      = '0;
      r.last = 1'b1;
      return r;
   endfunction

   // Updates the shadow bank for one accepted command and queues the
   // results it must produce, in order.
   function automatic void apply_command(req_type cmd);
      int v;
      int first;
      first = -1;
      case (cmd.opcode)
         OP_TICK: begin
            for (v = 0; v < VOICES; v++) begin
               advance_voice(v);
               expected_reports.push_back(voice_report(v, 1'b0, v == VOICES - 1));
            end
         end
         OP_KEY_ON: begin
            // lowest voice that is released and fully silent
            for (v = 0; v < VOICES; v++)
               if (first < 0 && !key_down[v] && env_stage[v] == STAGE_OFF)
                  first = v;
            if (first >= 0) begin
               held_key[first]  = cmd.note_key;
               key_down[first]  = 1'b1;
               env_level[first] = '0;
               env_stage[first] = STAGE_ATTACK;
               expected_reports.push_back(voice_report(first, 1'b1, 1'b1));
            end else begin
               expected_reports.push_back(no_voice_report());
            end
         end
         OP_KEY_OFF: begin
            // silent voices keep their stale key but are never touched
            for (v = 0; v < VOICES; v++) begin
               if (held_key[v] == cmd.note_key && env_stage[v] != STAGE_OFF) begin
                  key_down[v]  = 1'b0;
                  env_stage[v] = STAGE_RELEASE;
                  if (first < 0)
                     first = v;
               end
            end
            expected_reports.push_back(first >= 0 ? voice_report(first, 1'b1, 1'b1)
                                                  : no_voice_report());
         end
         default: ;  // unused opcode: taken, no result, no state change
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Result checker and watchdog, both sampling mid-cycle
   // -------------------------------------------------------------------------
   function automatic void report_error(string what, rsp_type want, rsp_type got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t %s: expected idx %0d lvl %0d stg %0d key %0d h%0b g%0b l%0b",
                  $realtime, what,
                  want.voice_index, want.level, want.stage, want.voice_key,
                  want.held, want.granted, want.last);
         $display("%0t %s: got      idx %0d lvl %0d stg %0d key %0d h%0b g%0b l%0b",
                  $realtime, what,
                  got.voice_index, got.level, got.stage, got.voice_key,
                  got.held, got.granted, got.last);
      end
   endfunction

   always @(negedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            report_error("unexpected result", '0, rsp_item);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_item.voice_index !== want.voice_index ||
                rsp_item.level       !== want.level       ||
                rsp_item.stage       !== want.stage       ||
                rsp_item.voice_key   !== want.voice_key   ||
                rsp_item.held        !== want.held        ||
                rsp_item.granted     !== want.granted     ||
                rsp_item.last        !== want.last)
               report_error("result mismatch", want, rsp_item);
         end
      end
   end

   // A command or result transaction at the coming edge keeps the run alive
   always @(negedge clock) begin : watchdog
      if (!reset) begin
         if ((start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $realtime, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers; all are entered and left at a rising edge
   // -------------------------------------------------------------------------
   function automatic req_type command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
      req_type r;
      r.opcode   = op;
      r.note_key = key;
      return r;
   endfunction

   // Sends one command. start is left high on return so back-to-back
   // commands never see start dropped and raised in the same step; every
   // caller that stops sending lowers it first.
   task automatic send_command(input req_type cmd);
      int   gap;
      logic taken;
      gap = 0;
      if (idle_enabled)
         while ($urandom_range(99) < 25)
            gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= cmd;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      apply_command(cmd);
   endtask

   // Stop sending and wait out every expected result plus the settle time
   task automatic wait_for_drain();
      start <= 1'b0;
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes all five registers back to back; only call with the bank idle
   task automatic load_settings(input logic mode, input logic [LEVEL_W-1:0] attack,
                                input logic [LEVEL_W-1:0] decay,
                                input logic [LEVEL_W-1:0] sustain,
                                input logic [LEVEL_W-1:0] release_rate);
      write_register(CSR_ENV_MODE,      CSR_DATA_W'(mode));
      write_register(CSR_ATTACK_STEP,   attack);
      write_register(CSR_DECAY_STEP,    decay);
      write_register(CSR_SUSTAIN_LEVEL, sustain);
      write_register(CSR_RELEASE_STEP,  release_rate);
      csr_we <= 1'b0;
      settings.env_mode      = mode;
      settings.attack_step   = attack;
      settings.decay_step    = decay;
      settings.sustain_level = sustain;
      settings.release_step  = release_rate;
   endtask

   // Returns every voice to off: full-scale release, key off on every
   // sounding voice, then one tick. Leaves the bank drained.
   task automatic silence_all_voices();
      int v;
      wait_for_drain();
      load_settings(settings.env_mode, settings.attack_step, settings.decay_step,
                    settings.sustain_level, FULL_SCALE);
      for (v = 0; v < VOICES; v++)
         if (env_stage[v] != STAGE_OFF)
            send_command(command(OP_KEY_OFF, held_key[v]));
      send_command(command(OP_TICK, '0));
      wait_for_drain();
   endtask

   // Mostly a small pool of keys so key offs find their voices, with the
   // two extremes and an occasional fully random key
   function automatic logic [KEY_W-1:0] random_key();
      int pick;
      pick = $urandom_range(11);
      case (pick)
         0:       return '0;
         1:       return '1;
         2:       return KEY_W'($urandom);
         default: return KEY_W'(57 + pick);
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] random_step();
      case ($urandom_range(11))
         0:       return LEVEL_W'(1);
         1:       return FULL_SCALE;
         2:       return '1;
         default: return LEVEL_W'($urandom_range(30000, 1500));
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] random_sustain();
      case ($urandom_range(9))
         0:       return '0;
         1:       return FULL_SCALE;
         2:       return '1;
         default: return LEVEL_W'($urandom_range(int'(FULL_SCALE)));
      endcase
   endfunction

   // Musically plausible traffic: ticks, key ons, and key offs that mostly
   // hit a sounding voice, with a little noise from the unused opcode
   function automatic req_type random_command();
      int pick;
      int v;
      pick = $urandom_range(99);
      v    = $urandom_range(VOICES - 1);
      if (pick < 40)
         return command(OP_TICK, KEY_W'($urandom));
      if (pick < 66)
         return command(OP_KEY_ON, random_key());
      if (pick < 94)
         return command(OP_KEY_OFF,
                        (env_stage[v] != STAGE_OFF && $urandom_range(9) < 7) ? held_key[v]
                                                                             : random_key());
      return command(OP_UNUSED, KEY_W'($urandom));
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset register values; fill the bank, overflow it, key off a key held
   // by two voices, key off a key nobody holds, the unused opcode, and a
   // key on that finds only releasing voices.
   task automatic test_voice_allocation();
      send_command(command(OP_KEY_ON, 7'd0));
      send_command(command(OP_KEY_ON, 7'd127));
      send_command(command(OP_KEY_ON, 7'd60));
      send_command(command(OP_KEY_ON, 7'd60));
      send_command(command(OP_KEY_ON, 7'd61));
      send_command(command(OP_KEY_ON, 7'd62));
      send_command(command(OP_KEY_ON, 7'd63));
      send_command(command(OP_KEY_ON, 7'd64));
      send_command(command(OP_KEY_ON, 7'd100));   // bank full, dropped
      send_command(command(OP_TICK, 7'd127));
      send_command(command(OP_KEY_OFF, 7'd60));   // releases two voices
      send_command(command(OP_KEY_OFF, 7'd99));   // nobody holds it
      send_command(command(OP_UNUSED, 7'd127));
      send_command(command(OP_KEY_ON, 7'd5));     // releasing voices are not free
      send_command(command(OP_TICK, 7'd0));
   endtask

   // Register extremes: full-scale steps, sustain above one, zero steps,
   // a mode switch with a voice in decay, and key off on a silent voice.
   task automatic test_envelope_limits();
      silence_all_voices();
      load_settings(1'b0, FULL_SCALE, '1, '1, FULL_SCALE);
      send_command(command(OP_KEY_ON, 7'd10));
      send_command(command(OP_TICK, '0));         // attack clamps, into decay
      send_command(command(OP_TICK, '0));         // decay hits saturated sustain
      send_command(command(OP_KEY_OFF, 7'd10));
      send_command(command(OP_TICK, '0));         // one-step release to off
      send_command(command(OP_KEY_OFF, 7'd10));   // silent voice left alone

      wait_for_drain();
      load_settings(1'b0, FULL_SCALE, LEVEL_W'(1), '0, '0);
      send_command(command(OP_KEY_ON, 7'd30));
      send_command(command(OP_TICK, '0));
      send_command(command(OP_TICK, '0));         // voice now mid-decay

      wait_for_drain();
      load_settings(1'b1, '0, LEVEL_W'(1), '0, '0);
      send_command(command(OP_KEY_ON, 7'd40));
      send_command(command(OP_TICK, '0));         // decay holds in AR, attack stuck
      send_command(command(OP_KEY_OFF, 7'd30));
      send_command(command(OP_TICK, '0));         // release with zero step holds

      silence_all_voices();
      load_settings(1'b1, FULL_SCALE, '0, FULL_SCALE, FULL_SCALE);
      send_command(command(OP_KEY_ON, 7'd50));
      send_command(command(OP_TICK, '0));         // AR: attack straight to release
      send_command(command(OP_TICK, '0));
   endtask

   task automatic run_random_phase(input int count, input logic mode,
                                   input bit with_idle, input bit pause_midway);
      int n;
      idle_enabled = with_idle;
      silence_all_voices();
      load_settings(mode, random_step(), random_step(), random_sustain(), random_step());
      for (n = 0; n < count; n++) begin
         // let the bank drain completely before carrying on
         if (pause_midway && n == count / 2)
            wait_for_drain();
         send_command(random_command());
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(30, 1'b0, 1'b1, 1'b0);
      run_random_phase(30, 1'b1, 1'b0, 1'b0);    // no idling at all
      run_random_phase(30, 1'b0, 1'b1, 1'b1);
      run_random_phase(30, 1'($urandom_range(1)), 1'b1, 1'b0);
      idle_enabled = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int v;
      for (v = 0; v < VOICES; v++) begin
         env_stage[v] = STAGE_OFF;
         env_level[v] = '0;
         held_key[v]  = '0;
         key_down[v]  = 1'b0;
      end
      settings.env_mode      = 1'b0;
      settings.attack_step   = LEVEL_W'(66);
      settings.decay_step    = LEVEL_W'(66);
      settings.sustain_level = LEVEL_W'(45875);
      settings.release_step  = LEVEL_W'(66);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_voice_allocation();
      test_envelope_limits();
      test_random_traffic();

      wait_for_drain();
      error_count += expected_reports.size();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### polyphonic_voice_envelope_manager.f
src/pvem_pkg.sv
src/pvem_front.sv
src/pvem_queue.sv
src/pvem_back.sv
src/polyphonic_voice_envelope_manager.sv
verif/testbench.sv
